FILE: hw/rtl/scp_pkg.sv
// ============================================================================
// scp_pkg: shared types and constants of the spring constraint projection
// Field widths of the fixed-point words and the default datapath width.
// ============================================================================
package scp_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FIELD_BITS        = 32;
   localparam int UFIELD_BITS       = 31;
   localparam int FRAC_BITS         = 16;

   typedef logic signed [FIELD_BITS-1:0] field_type;
   typedef logic        [UFIELD_BITS-1:0] ufield_type;

endpackage

FILE: hw/rtl/scp_channels.sv
// ============================================================================
// scp_channels: valid/ready channels of the spring constraint projection
// One channel carries a spring constraint, the other its projection result.
// ============================================================================
interface scp_req_if;
   logic                valid;
   logic                ready;
   scp_pkg::field_type  head_x;
   scp_pkg::field_type  head_y;
   scp_pkg::field_type  head_z;
   scp_pkg::field_type  tail_x;
   scp_pkg::field_type  tail_y;
   scp_pkg::field_type  tail_z;
   scp_pkg::field_type  dual_x;
   scp_pkg::field_type  dual_y;
   scp_pkg::field_type  dual_z;
   scp_pkg::ufield_type rest_length;
   scp_pkg::ufield_type stiffness;
   scp_pkg::ufield_type weight;

   modport source (
      output valid, head_x, head_y, head_z, tail_x, tail_y, tail_z,
             dual_x, dual_y, dual_z, rest_length, stiffness, weight,
      input  ready
   );
   modport sink (
      input  valid, head_x, head_y, head_z, tail_x, tail_y, tail_z,
             dual_x, dual_y, dual_z, rest_length, stiffness, weight,
      output ready
   );
endinterface

interface scp_rsp_if;
   logic               valid;
   logic               ready;
   scp_pkg::field_type proj_x;
   scp_pkg::field_type proj_y;
   scp_pkg::field_type proj_z;
   scp_pkg::field_type dual_new_x;
   scp_pkg::field_type dual_new_y;
   scp_pkg::field_type dual_new_z;
   logic               divide_fault;

   modport source (
      output valid, proj_x, proj_y, proj_z, dual_new_x, dual_new_y, dual_new_z,
             divide_fault,
      input  ready
   );
   modport sink (
      input  valid, proj_x, proj_y, proj_z, dual_new_x, dual_new_y, dual_new_z,
             divide_fault,
      output ready
   );
endinterface

FILE: hw/rtl/scp_sqrt_pipe.sv
// ============================================================================
// scp_sqrt_pipe: pipelined integer square root
// One result bit per stage, restoring method; side data rides along.
// ============================================================================
module scp_sqrt_pipe #(
   parameter int RAD_BITS  = 64,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [RAD_BITS-1:0]    in_rad,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_valid,
   output logic [RAD_BITS/2-1:0]  out_root,
   output logic [SIDE_BITS-1:0]   out_side
);

   localparam int ROOT_BITS = RAD_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 2;

   logic                 vld_ff  [1:ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [1:ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [1:ROOT_BITS];
   logic [RAD_BITS-1:0]  rad_ff  [1:ROOT_BITS];
   logic [SIDE_BITS-1:0] side_ff [1:ROOT_BITS];

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
      logic                 v_src;
      logic [REM_BITS-1:0]  rem_src;
      logic [ROOT_BITS-1:0] root_src;
      logic [RAD_BITS-1:0]  rad_src;
      logic [SIDE_BITS-1:0] side_src;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      logic                 take;
      logic [REM_BITS-1:0]  rem_in;
      logic [ROOT_BITS-1:0] root_in;
      logic [RAD_BITS-1:0]  rad_in;

      if (j == 0) begin : g_load
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign side_src = in_side;
      end else begin : g_chain
         assign v_src    = vld_ff[j];
         assign rem_src  = rem_ff[j];
         assign root_src = root_ff[j];
         assign rad_src  = rad_ff[j];
         assign side_src = side_ff[j];
      end

      always_comb begin
         rem_sh  = {rem_src[REM_BITS-3:0], rad_src[RAD_BITS-1 -: 2]};
         trial   = {root_src, 2'b01};
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_src[ROOT_BITS-2:0], take};
         rad_in  = {rad_src[RAD_BITS-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[j+1] <= v_src;
         end
         if (adv) begin
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
            rad_ff[j+1]  <= rad_in;
            side_ff[j+1] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_BITS];
   assign out_root  = root_ff[ROOT_BITS];
   assign out_side  = side_ff[ROOT_BITS];

endmodule

FILE: hw/rtl/scp_div_pipe.sv
// ============================================================================
// scp_div_pipe: pipelined unsigned divider, several lanes, shared divisor
// One quotient bit per stage, restoring method; side data rides along.
// ============================================================================
module scp_div_pipe #(
   parameter int LANES     = 3,
   parameter int NUM_BITS  = 62,
   parameter int DEN_BITS  = 32,
   parameter int QUO_BITS  = 31,
   parameter int SIDE_BITS = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  logic [LANES-1:0][NUM_BITS-1:0]   in_num,
   input  logic [DEN_BITS-1:0]              in_den,
   input  logic [SIDE_BITS-1:0]             in_side,
   output logic                             out_valid,
   output logic [LANES-1:0][QUO_BITS-1:0]   out_quo,
   output logic [SIDE_BITS-1:0]             out_side
);

   // the upper numerator bits must already sit below the divisor
   localparam int HEAD_BITS = NUM_BITS - QUO_BITS;

   logic                             vld_ff  [1:QUO_BITS];
   logic [LANES-1:0][DEN_BITS-1:0]   rem_ff  [1:QUO_BITS];
   logic [LANES-1:0][QUO_BITS-1:0]   acc_ff  [1:QUO_BITS];
   logic [DEN_BITS-1:0]              den_ff  [1:QUO_BITS];
   logic [SIDE_BITS-1:0]             side_ff [1:QUO_BITS];

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
      logic                           v_src;
      logic [LANES-1:0][DEN_BITS-1:0] rem_src;
      logic [LANES-1:0][QUO_BITS-1:0] acc_src;
      logic [DEN_BITS-1:0]            den_src;
      logic [SIDE_BITS-1:0]           side_src;
      logic [LANES-1:0][DEN_BITS-1:0] rem_in;
      logic [LANES-1:0][QUO_BITS-1:0] acc_in;

      if (j == 0) begin : g_load
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_src[l] = DEN_BITS'(in_num[l][NUM_BITS-1 -: HEAD_BITS]);
               acc_src[l] = in_num[l][QUO_BITS-1:0];
            end
         end
         assign v_src    = in_valid;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_chain
         assign v_src    = vld_ff[j];
         assign rem_src  = rem_ff[j];
         assign acc_src  = acc_ff[j];
         assign den_src  = den_ff[j];
         assign side_src = side_ff[j];
      end

      always_comb begin
         logic [DEN_BITS:0] trial;
         logic [DEN_BITS:0] diff;
         logic              take;
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_src[l], acc_src[l][QUO_BITS-1]};
            diff  = trial - {1'b0, den_src};
            take  = (trial >= {1'b0, den_src});
            rem_in[l] = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            acc_in[l] = {acc_src[l][QUO_BITS-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[j+1] <= v_src;
         end
         if (adv) begin
            rem_ff[j+1]  <= rem_in;
            acc_ff[j+1]  <= acc_in;
            den_ff[j+1]  <= den_src;
            side_ff[j+1] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QUO_BITS];
   assign out_quo   = acc_ff[QUO_BITS];
   assign out_side  = side_ff[QUO_BITS];

endmodule

FILE: hw/rtl/spring_constraint_projection.sv
// ============================================================================
// spring_constraint_projection: ADMM local step for one spring constraint
// Projects head - tail + dual onto the rest-length sphere and blends it.
// ============================================================================
// Usage:
//   req_bus carries one spring per transfer: both end points, the scaled
//   dual (Q16.16), rest length, stiffness and weight (UQ15.16). rsp_bus returns one
//   result per spring: the new auxiliary vector, the new dual and a flag for
//   a zero blend denominator (the vector then passes through unchanged).
//   Throughput: one spring per cycle unless rsp_bus stalls. The work is a
//   single pipeline: four setup stages, a 32-stage square root, a product
//   stage and a 31-stage divider for the sphere projection, four blend
//   stages, a 33-stage divider for the blend and two output stages. Valid
//   bits travel with the data.
//   Stall: the whole pipeline holds while a result waits on rsp_bus; req_bus
//   ready drops only then, so nothing is lost or repeated.
//   Reset (synchronous): clears every valid bit; payload registers keep junk.
//   WORD_BITS sets the saturation range of both result vectors (capped at 32).
// ============================================================================
module spring_constraint_projection #(
   parameter int WORD_BITS = scp_pkg::WORD_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   scp_req_if.sink   req_bus,
   scp_rsp_if.source rsp_bus
);

   localparam int FB     = scp_pkg::FIELD_BITS;
   localparam int SAT_BITS = (WORD_BITS < FB) ? WORD_BITS : FB;
   localparam int ZB     = FB + 2;                               // z = d + dual
   localparam int MB     = ZB - 1;                               // |z|
   localparam int LB     = scp_pkg::UFIELD_BITS;
   localparam int KB     = 2 * LB - scp_pkg::FRAC_BITS;          // stiffness * rest
   localparam int KPB    = 28;                                   // scaled stiffness
   localparam int TB     = 5;                                    // scale shift
   localparam int SQB    = 2 * LB;
   localparam int RADB   = 64;
   localparam int ROOTB  = RADB / 2;
   localparam int DENB   = 32;
   localparam int DB     = ZB + 1;                               // p - z
   localparam int DMB    = MB;                                   // |p - z|
   localparam int PRB    = KPB + DMB;
   localparam int RB     = ZB + 2;                               // before saturation

   localparam logic signed [RB-1:0] SAT_HI = (RB'(1) <<< (SAT_BITS - 1)) - RB'(1);
   localparam logic signed [RB-1:0] SAT_LO = -SAT_HI - RB'(1);

   typedef struct packed {
      logic [2:0][ZB-1:0] z;
      logic [KPB-1:0]     kp;
      logic [DENB-1:0]    den;
      logic               fault;
   } carry_type;

   typedef struct packed {
      logic [2:0][LB-1:0] zs;
      logic [LB-1:0]      rest;
      carry_type          c;
   } sq_side_type;

   typedef struct packed {
      logic [2:0][ZB-1:0] z;
      logic [2:0]         neg;
      logic               fault;
   } d2_side_type;

   function automatic logic [FB-1:0] sat_word(input logic signed [RB-1:0] v);
      logic signed [RB-1:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return c[FB-1:0];
   endfunction

   // advance everything whenever the output register is free or being taken
   logic adv;
   logic out_vld_ff;

   assign adv           = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------------------------------------------------------- stage A
   // form z = head - tail + dual and the raw stiffness product
   logic                  a_vld_ff;
   logic signed [ZB-1:0]  a_z_ff [3];
   logic signed [ZB-1:0]  a_z_in [3];
   logic [LB-1:0]         a_rest_ff;
   logic [LB-1:0]         a_w_ff;
   logic [KB-1:0]         a_k_ff;
   logic [SQB-1:0]        a_kprod;

   always_comb begin
      a_z_in[0] = ZB'(req_bus.head_x) - ZB'(req_bus.tail_x) + ZB'(req_bus.dual_x);
      a_z_in[1] = ZB'(req_bus.head_y) - ZB'(req_bus.tail_y) + ZB'(req_bus.dual_y);
      a_z_in[2] = ZB'(req_bus.head_z) - ZB'(req_bus.tail_z) + ZB'(req_bus.dual_z);
      a_kprod   = SQB'(req_bus.stiffness) * SQB'(req_bus.rest_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_bus.valid;
      end
      if (adv) begin
         a_z_ff    <= a_z_in;
         a_rest_ff <= req_bus.rest_length;
         a_w_ff    <= req_bus.weight;
         a_k_ff    <= a_kprod[SQB-1:scp_pkg::FRAC_BITS];
      end
   end

   // ---------------------------------------------------------------- stage B
   // scale |z| into 31 bits; find the shift that brings k below 2^28
   logic                 b_vld_ff;
   logic signed [ZB-1:0] b_z_ff [3];
   logic [LB-1:0]        b_zs_ff [3];
   logic [LB-1:0]        b_zs_in [3];
   logic [LB-1:0]        b_rest_ff;
   logic [LB-1:0]        b_w_ff;
   logic [KB-1:0]        b_k_ff;
   logic [TB-1:0]        b_t_ff;
   logic [TB-1:0]        b_t_in;
   logic [MB-1:0]        b_mag [3];
   logic                 b_top2;
   logic                 b_top1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_mag[i] = a_z_ff[i][ZB-1] ? MB'(-a_z_ff[i]) : MB'(a_z_ff[i]);
      end
      b_top2 = b_mag[0][MB-1] | b_mag[1][MB-1] | b_mag[2][MB-1];
      b_top1 = b_mag[0][MB-2] | b_mag[1][MB-2] | b_mag[2][MB-2];
      for (int i = 0; i < 3; i++) begin
         priority if (b_top2) begin
            b_zs_in[i] = b_mag[i][MB-1:2];
         end else if (b_top1) begin
            b_zs_in[i] = b_mag[i][MB-2:1];
         end else begin
            b_zs_in[i] = b_mag[i][LB-1:0];
         end
      end
      // highest set bit at or above KPB wins
      b_t_in = '0;
      for (int b = KPB; b < KB; b++) begin
         if (a_k_ff[b]) begin
            b_t_in = TB'(b - KPB + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
      if (adv) begin
         b_z_ff    <= a_z_ff;
         b_zs_ff   <= b_zs_in;
         b_rest_ff <= a_rest_ff;
         b_w_ff    <= a_w_ff;
         b_k_ff    <= a_k_ff;
         b_t_ff    <= b_t_in;
      end
   end

   // ---------------------------------------------------------------- stage C
   // square the scaled components; scale stiffness and weight
   logic                 c_vld_ff;
   logic signed [ZB-1:0] c_z_ff [3];
   logic [LB-1:0]        c_zs_ff [3];
   logic [LB-1:0]        c_rest_ff;
   logic [SQB-1:0]       c_sq_ff [3];
   logic [SQB-1:0]       c_sq_in [3];
   logic [KPB-1:0]       c_kp_ff;
   logic [LB-1:0]        c_wp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_sq_in[i] = SQB'(b_zs_ff[i]) * SQB'(b_zs_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
      if (adv) begin
         c_z_ff    <= b_z_ff;
         c_zs_ff   <= b_zs_ff;
         c_rest_ff <= b_rest_ff;
         c_sq_ff   <= c_sq_in;
         c_kp_ff   <= KPB'(b_k_ff >> b_t_ff);
         c_wp_ff   <= b_w_ff >> b_t_ff;
      end
   end

   // ---------------------------------------------------------------- stage D
   // sum of squares; blend denominator, forced to one when it is zero
   logic              d_vld_ff;
   logic [RADB-1:0]   d_sum_ff;
   logic [RADB-1:0]   d_sum_in;
   sq_side_type       d_side_ff;
   sq_side_type       d_side_in;
   logic [DENB-1:0]   d_den;

   always_comb begin
      d_sum_in = RADB'(c_sq_ff[0]) + RADB'(c_sq_ff[1]) + RADB'(c_sq_ff[2]);
      d_den    = DENB'(c_kp_ff) + DENB'(c_wp_ff);
      for (int i = 0; i < 3; i++) begin
         d_side_in.zs[i]  = c_zs_ff[i];
         d_side_in.c.z[i] = c_z_ff[i];
      end
      d_side_in.rest    = c_rest_ff;
      d_side_in.c.kp    = c_kp_ff;
      d_side_in.c.fault = (d_den == '0);
      d_side_in.c.den   = (d_den == '0) ? DENB'(1) : d_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
      if (adv) begin
         d_sum_ff  <= d_sum_in;
         d_side_ff <= d_side_in;
      end
   end

   // ------------------------------------------------------------ square root
   logic                           sq_vld;
   logic [ROOTB-1:0]               sq_root;
   logic [$bits(sq_side_type)-1:0] sq_side_vec;
   sq_side_type                    sq_side;

   scp_sqrt_pipe #(
      .RAD_BITS  (RADB),
      .SIDE_BITS ($bits(sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_vld_ff),
      .in_rad    (d_sum_ff),
      .in_side   (d_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side_vec)
   );

   assign sq_side = sq_side_vec;

   // ---------------------------------------------------------------- stage E
   // rest * |zs| over the norm; a zero norm means zero numerators, so use 1
   logic                     e_vld_ff;
   logic [2:0][SQB-1:0]      e_num_ff;
   logic [2:0][SQB-1:0]      e_num_in;
   logic [DENB-1:0]          e_n_ff;
   carry_type                e_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_num_in[i] = SQB'(sq_side.rest) * SQB'(sq_side.zs[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= sq_vld;
      end
      if (adv) begin
         e_num_ff  <= e_num_in;
         e_n_ff    <= (sq_root == '0) ? DENB'(1) : DENB'(sq_root);
         e_side_ff <= sq_side.c;
      end
   end

   // ------------------------------------------------------ projection divide
   logic                         q1_vld;
   logic [2:0][LB-1:0]           q1_quo;
   logic [$bits(carry_type)-1:0] q1_side_vec;
   carry_type                    q1_side;

   scp_div_pipe #(
      .LANES     (3),
      .NUM_BITS  (SQB),
      .DEN_BITS  (DENB),
      .QUO_BITS  (LB),
      .SIDE_BITS ($bits(carry_type))
   ) u_div_proj (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_vld_ff),
      .in_num    (e_num_ff),
      .in_den    (e_n_ff),
      .in_side   (e_side_ff),
      .out_valid (q1_vld),
      .out_quo   (q1_quo),
      .out_side  (q1_side_vec)
   );

   assign q1_side = q1_side_vec;

   // ---------------------------------------------------------------- stage F
   // restore the sign of z onto the projection
   logic                 f_vld_ff;
   logic signed [FB-1:0] f_p_ff [3];
   logic signed [FB-1:0] f_p_in [3];
   carry_type            f_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_p_in[i] = q1_side.z[i][ZB-1] ? -$signed({1'b0, q1_quo[i]})
                                       :  $signed({1'b0, q1_quo[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= q1_vld;
      end
      if (adv) begin
         f_p_ff    <= f_p_in;
         f_side_ff <= q1_side;
      end
   end

   // ---------------------------------------------------------------- stage G
   // delta = p - z
   logic                 g_vld_ff;
   logic signed [DB-1:0] g_delta_ff [3];
   logic signed [DB-1:0] g_delta_in [3];
   carry_type            g_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_delta_in[i] = DB'(f_p_ff[i]) - DB'($signed(f_side_ff.z[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
      if (adv) begin
         g_delta_ff <= g_delta_in;
         g_side_ff  <= f_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage H
   // split delta into sign and magnitude
   logic           h_vld_ff;
   logic [DMB-1:0] h_dmag_ff [3];
   logic [DMB-1:0] h_dmag_in [3];
   logic [2:0]     h_neg_ff;
   logic [2:0]     h_neg_in;
   carry_type      h_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_neg_in[i]  = g_delta_ff[i][DB-1];
         h_dmag_in[i] = h_neg_in[i] ? DMB'(-g_delta_ff[i]) : DMB'(g_delta_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
      if (adv) begin
         h_dmag_ff <= h_dmag_in;
         h_neg_ff  <= h_neg_in;
         h_side_ff <= g_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage I
   // k' * |delta|
   logic                 i_vld_ff;
   logic [2:0][PRB-1:0]  i_prod_ff;
   logic [2:0][PRB-1:0]  i_prod_in;
   logic [DENB-1:0]      i_den_ff;
   d2_side_type          i_side_ff;
   d2_side_type          i_side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         i_prod_in[i] = PRB'(h_side_ff.kp) * PRB'(h_dmag_ff[i]);
      end
      i_side_in.z     = h_side_ff.z;
      i_side_in.neg   = h_neg_ff;
      i_side_in.fault = h_side_ff.fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         i_vld_ff <= h_vld_ff;
      end
      if (adv) begin
         i_prod_ff <= i_prod_in;
         i_den_ff  <= h_side_ff.den;
         i_side_ff <= i_side_in;
      end
   end

   // ----------------------------------------------------------- blend divide
   // a zero denominator came with k' = 0, so the quotient is zero over one
   logic                           q2_vld;
   logic [2:0][DMB-1:0]            q2_quo;
   logic [$bits(d2_side_type)-1:0] q2_side_vec;
   d2_side_type                    q2_side;

   scp_div_pipe #(
      .LANES     (3),
      .NUM_BITS  (PRB),
      .DEN_BITS  (DENB),
      .QUO_BITS  (DMB),
      .SIDE_BITS ($bits(d2_side_type))
   ) u_div_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (i_vld_ff),
      .in_num    (i_prod_ff),
      .in_den    (i_den_ff),
      .in_side   (i_side_ff),
      .out_valid (q2_vld),
      .out_quo   (q2_quo),
      .out_side  (q2_side_vec)
   );

   assign q2_side = q2_side_vec;

   // ---------------------------------------------------------------- stage J
   // new z = z +/- q; new dual = z - new z = -/+ q
   logic                 j_vld_ff;
   logic signed [RB-1:0] j_zn_ff [3];
   logic signed [RB-1:0] j_zn_in [3];
   logic signed [RB-1:0] j_du_ff [3];
   logic signed [RB-1:0] j_du_in [3];
   logic                 j_fault_ff;
   logic signed [RB-1:0] j_q [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         j_q[i] = RB'($signed({1'b0, q2_quo[i]}));
         if (q2_side.neg[i]) begin
            j_zn_in[i] = RB'($signed(q2_side.z[i])) - j_q[i];
            j_du_in[i] = j_q[i];
         end else begin
            j_zn_in[i] = RB'($signed(q2_side.z[i])) + j_q[i];
            j_du_in[i] = -j_q[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else if (adv) begin
         j_vld_ff <= q2_vld;
      end
      if (adv) begin
         j_zn_ff    <= j_zn_in;
         j_du_ff    <= j_du_in;
         j_fault_ff <= q2_side.fault;
      end
   end

   // ---------------------------------------------------------------- stage K
   // saturate into the output register
   scp_pkg::field_type out_proj_ff [3];
   scp_pkg::field_type out_dual_ff [3];
   logic               out_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= j_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            out_proj_ff[i] <= sat_word(j_zn_ff[i]);
            out_dual_ff[i] <= sat_word(j_du_ff[i]);
         end
         out_fault_ff <= j_fault_ff;
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.proj_x       = out_proj_ff[0];
   assign rsp_bus.proj_y       = out_proj_ff[1];
   assign rsp_bus.proj_z       = out_proj_ff[2];
   assign rsp_bus.dual_new_x   = out_dual_ff[0];
   assign rsp_bus.dual_new_y   = out_dual_ff[1];
   assign rsp_bus.dual_new_z   = out_dual_ff[2];
   assign rsp_bus.divide_fault = out_fault_ff;

endmodule

FILE: hw/rtl/scp_checker.sv
// ============================================================================
// scp_checker: port-level checks of the spring constraint projection
// Watches both channels; attached to the top level by bind.
// ============================================================================
module scp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input scp_pkg::field_type proj_x,
   input scp_pkg::field_type proj_y,
   input scp_pkg::field_type proj_z,
   input scp_pkg::field_type dual_new_x,
   input scp_pkg::field_type dual_new_y,
   input scp_pkg::field_type dual_new_z,
   input logic               divide_fault
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(proj_x) && $stable(proj_y) && $stable(proj_z)
         && $stable(dual_new_x) && $stable(dual_new_y) && $stable(dual_new_z)
         && $stable(divide_fault))
      else $error("stalled result changed");

   // an empty output stage must take a transfer
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output");

   // a passed-through vector leaves a zero dual
   a_fault_dual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divide_fault |-> dual_new_x == '0 && dual_new_y == '0
         && dual_new_z == '0)
      else $error("fault result with nonzero dual");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind spring_constraint_projection scp_checker u_scp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .proj_x       (rsp_bus.proj_x),
   .proj_y       (rsp_bus.proj_y),
   .proj_z       (rsp_bus.proj_z),
   .dual_new_x   (rsp_bus.dual_new_x),
   .dual_new_y   (rsp_bus.dual_new_y),
   .dual_new_z   (rsp_bus.dual_new_z),
   .divide_fault (rsp_bus.divide_fault)
);
